// ===== hdl/swrl_pkg.sv =====
// Shared types and constants for the sliding window rate limiter.
`default_nettype none
package swrl_pkg;

   // fixed field widths
   localparam int unsigned CLIENT_IN_BITS = 4;
   localparam int unsigned TIME_BITS      = 32;
   localparam int unsigned MAX_REQ_BITS   = 7;
   localparam int unsigned WINDOW_BITS    = 32;
   localparam int unsigned OUT_COUNT_BITS = 7;
   localparam int unsigned CSR_INDEX_BITS = 4;
   localparam int unsigned CSR_DATA_BITS  = 32;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_REQUESTS = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_TICKS = 4'd1;

   // register reset values
   localparam logic [MAX_REQ_BITS-1:0] MAX_REQ_RESET = 7'd64;
   localparam logic [WINDOW_BITS-1:0]  WINDOW_RESET  = 32'd1000000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_DECIDE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch request, load client ring pointers
      logic rd_issue;  // read oldest stamp
      logic pop;       // drop oldest entry
      logic commit;    // decide, write back, emit response
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic cnt_zero;  // no live entries left
      logic expire;    // oldest entry is out of the window
   } status_type;

endpackage
`default_nettype wire

// ===== hdl/swrl_ctrl.sv =====
// Sequencer for the rate limiter: expiry loop and decision steps.
`default_nettype none
module swrl_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire swrl_pkg::status_type status,
   output logic                      busy,
   output swrl_pkg::cmd_type         cmd
);

   swrl_pkg::state_type state_ff;
   swrl_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swrl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         swrl_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = swrl_pkg::ST_READ;
            end
         end
         swrl_pkg::ST_READ: begin
            if (status.cnt_zero) begin
               state_in = swrl_pkg::ST_DECIDE;
            end else begin
               cmd.rd_issue = 1'b1;
               state_in     = swrl_pkg::ST_CHECK;
            end
         end
         swrl_pkg::ST_CHECK: begin
            if (status.expire) begin
               cmd.pop  = 1'b1;
               state_in = swrl_pkg::ST_READ;
            end else begin
               state_in = swrl_pkg::ST_DECIDE;
            end
         end
         swrl_pkg::ST_DECIDE: begin
            cmd.commit = 1'b1;
            state_in   = swrl_pkg::ST_IDLE;
         end
         default: begin
            state_in = swrl_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== hdl/swrl_datapath.sv =====
// Datapath: per-client ring pointers, timestamp memory, registers, response.
`default_nettype none
module swrl_datapath #(
   parameter int unsigned NUM_CLIENTS = 16,
   parameter int unsigned RING_DEPTH  = 64,
   parameter int unsigned STAMP_BITS  = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire swrl_pkg::cmd_type                     cmd,
   output swrl_pkg::status_type                       status,
   input  wire logic [swrl_pkg::CLIENT_IN_BITS-1:0]   req_client_index,
   input  wire logic [swrl_pkg::TIME_BITS-1:0]        req_request_time,
   input  wire logic                                  csr_we,
   input  wire logic [swrl_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [swrl_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output logic                                       rsp_strobe,
   output logic                                       rsp_allowed,
   output logic [swrl_pkg::OUT_COUNT_BITS-1:0]        rsp_occupancy,
   output logic [swrl_pkg::OUT_COUNT_BITS-1:0]        rsp_expired_count
);

   localparam int unsigned CLW       = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
   localparam int unsigned HW        = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int unsigned CNTW      = $clog2(RING_DEPTH + 1);
   localparam int unsigned SW        = CNTW + 1;
   localparam int unsigned MEM_DEPTH = NUM_CLIENTS * RING_DEPTH;
   localparam int unsigned AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int unsigned CMPW      = (STAMP_BITS > swrl_pkg::WINDOW_BITS) ?
                                       STAMP_BITS : swrl_pkg::WINDOW_BITS;
   localparam int unsigned LIMW      = (CNTW > swrl_pkg::MAX_REQ_BITS) ?
                                       CNTW : swrl_pkg::MAX_REQ_BITS;
   localparam int unsigned MAP_DEPTH = 1 << swrl_pkg::CLIENT_IN_BITS;

   // client index folded into range
   logic [CLW-1:0] client_map [MAP_DEPTH];
   for (genvar g = 0; g < MAP_DEPTH; g++) begin : g_map
      localparam int unsigned REDUCED = g % NUM_CLIENTS;
      assign client_map[g] = CLW'(REDUCED);
   end

   logic [CLW-1:0] client_sel;
   assign client_sel = client_map[req_client_index];

   // configuration
   logic [swrl_pkg::MAX_REQ_BITS-1:0] max_req_ff;
   logic [swrl_pkg::WINDOW_BITS-1:0]  window_ff;

   // per-client ring pointers
   logic [HW-1:0]   ring_head_ff  [NUM_CLIENTS];
   logic [CNTW-1:0] ring_count_ff [NUM_CLIENTS];

   // working registers
   logic [CLW-1:0]        client_ff;
   logic [STAMP_BITS-1:0] now_ff;
   logic [AW-1:0]         base_ff;
   logic [HW-1:0]         head_ff, head_in;
   logic [CNTW-1:0]       cnt_ff, cnt_in;
   logic [CNTW-1:0]       exp_ff, exp_in;
   logic [STAMP_BITS-1:0] rd_ff;

   logic                                rsp_strobe_ff;
   logic                                rsp_allowed_ff;
   logic [swrl_pkg::OUT_COUNT_BITS-1:0] rsp_occ_ff;
   logic [swrl_pkg::OUT_COUNT_BITS-1:0] rsp_exp_ff;

   // timestamp memory
   logic [STAMP_BITS-1:0] stamp_mem [MEM_DEPTH];

   logic [HW-1:0]         head_inc;
   logic [SW-1:0]         slot_sum;
   logic [HW-1:0]         slot_wr;
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         rd_addr;
   logic [STAMP_BITS-1:0] age;
   logic [LIMW-1:0]       limit;
   logic                  admit;
   logic [CNTW-1:0]       cnt_final;

   assign head_inc = (head_ff == HW'(RING_DEPTH - 1)) ? '0 : head_ff + HW'(1);
   assign slot_sum = SW'(head_ff) + SW'(cnt_ff);
   assign slot_wr  = (slot_sum >= SW'(RING_DEPTH)) ? HW'(slot_sum - SW'(RING_DEPTH))
                                                   : HW'(slot_sum);
   assign wr_addr  = base_ff + AW'(slot_wr);
   assign rd_addr  = base_ff + AW'(head_ff);

   assign age   = now_ff - rd_ff;
   assign limit = (LIMW'(max_req_ff) > LIMW'(RING_DEPTH)) ? LIMW'(RING_DEPTH)
                                                         : LIMW'(max_req_ff);
   assign admit     = LIMW'(cnt_ff) < limit;
   assign cnt_final = admit ? cnt_ff + CNTW'(1) : cnt_ff;

   assign status.cnt_zero = (cnt_ff == '0);
   assign status.expire   = CMPW'(age) >= CMPW'(window_ff);

   always_comb begin
      head_in = head_ff;
      cnt_in  = cnt_ff;
      exp_in  = exp_ff;
      if (cmd.capture) begin
         head_in = ring_head_ff[client_sel];
         cnt_in  = ring_count_ff[client_sel];
         exp_in  = '0;
      end else if (cmd.pop) begin
         head_in = head_inc;
         cnt_in  = cnt_ff - CNTW'(1);
         exp_in  = exp_ff + CNTW'(1);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         max_req_ff    <= swrl_pkg::MAX_REQ_RESET;
         window_ff     <= swrl_pkg::WINDOW_RESET;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < NUM_CLIENTS; i++) begin
            ring_head_ff[i]  <= '0;
            ring_count_ff[i] <= '0;
         end
      end else begin
         rsp_strobe_ff <= cmd.commit;
         if (cmd.commit) begin
            ring_head_ff[client_ff]  <= head_ff;
            ring_count_ff[client_ff] <= cnt_final;
         end
         if (csr_we) begin
            case (csr_index)
               swrl_pkg::CSR_MAX_REQUESTS: begin
                  max_req_ff <= csr_wdata[swrl_pkg::MAX_REQ_BITS-1:0];
               end
               swrl_pkg::CSR_WINDOW_TICKS: begin
                  window_ff <= csr_wdata[swrl_pkg::WINDOW_BITS-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      head_ff <= head_in;
      cnt_ff  <= cnt_in;
      exp_ff  <= exp_in;
      if (cmd.capture) begin
         client_ff <= client_sel;
         now_ff    <= STAMP_BITS'(req_request_time);
         base_ff   <= AW'(client_sel) * AW'(RING_DEPTH);
      end
      if (cmd.commit) begin
         rsp_allowed_ff <= admit;
         rsp_occ_ff     <= swrl_pkg::OUT_COUNT_BITS'(cnt_final);
         rsp_exp_ff     <= swrl_pkg::OUT_COUNT_BITS'(exp_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && admit) begin
         stamp_mem[wr_addr] <= now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         rd_ff <= stamp_mem[rd_addr];
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_allowed       = rsp_allowed_ff;
   assign rsp_occupancy     = rsp_occ_ff;
   assign rsp_expired_count = rsp_exp_ff;

endmodule
`default_nettype wire

// ===== hdl/sliding_window_rate_limiter_top.sv =====
// Top level of the sliding window log rate limiter.
// Requests are taken only in IDLE, start is ignored while busy. READ and CHECK
//   repeat, popping one expired entry each time, until an unexpired entry or
//   none is left; DECIDE then commits and registers the response strobe.
// Reset clears ring pointers, registers and the sequencer, not the timestamp
//   memory. The receiver cannot stall the response strobe.
`default_nettype none
module sliding_window_rate_limiter_top #(
   parameter int unsigned NUM_CLIENTS = 16,
   parameter int unsigned RING_DEPTH  = 64,
   parameter int unsigned STAMP_BITS  = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [swrl_pkg::CLIENT_IN_BITS-1:0] req_client_index,
   input  wire logic [swrl_pkg::TIME_BITS-1:0]      req_request_time,
   // response channel
   output logic                                     rsp_strobe,
   output logic                                     rsp_allowed,
   output logic [swrl_pkg::OUT_COUNT_BITS-1:0]      rsp_occupancy,
   output logic [swrl_pkg::OUT_COUNT_BITS-1:0]      rsp_expired_count,
   // register write port
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [swrl_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [swrl_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   swrl_pkg::cmd_type    cmd;
   swrl_pkg::status_type status;

   // register writes are taken only while no request is in flight or arriving
   assign csr_ready = ~busy & ~start;

   // sequencer: accept, expire oldest entries one by one, decide
   swrl_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   // rings, timestamp memory, age compare, response registers
   swrl_datapath #(
      .NUM_CLIENTS (NUM_CLIENTS),
      .RING_DEPTH  (RING_DEPTH),
      .STAMP_BITS  (STAMP_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_client_index  (req_client_index),
      .req_request_time  (req_request_time),
      .csr_we            (csr_valid & csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_strobe        (rsp_strobe),
      .rsp_allowed       (rsp_allowed),
      .rsp_occupancy     (rsp_occupancy),
      .rsp_expired_count (rsp_expired_count)
   );

endmodule
`default_nettype wire

// ===== hdl/swrl_checker.sv =====
// Port-level checks on request and response timing, bound to the top level.
`default_nettype none
module swrl_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                start,
   input wire logic                                busy,
   input wire logic                                rsp_strobe,
   input wire logic                                rsp_allowed,
   input wire logic [swrl_pkg::OUT_COUNT_BITS-1:0] rsp_occupancy
);

   // a response lasts one cycle and cannot repeat at once
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for two cycles");

   // an accepted request makes the block busy with no response yet
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_strobe)
      else $error("accepted request did not start work");

   // finishing work always delivers a response
   a_done_response: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_strobe)
      else $error("request finished without a response");

   // an admitted request is held, so occupancy is not zero
   a_admit_occupancy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_allowed |-> rsp_occupancy != '0)
      else $error("admitted request with zero occupancy");

endmodule

bind sliding_window_rate_limiter_top swrl_checker u_swrl_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_allowed   (rsp_allowed),
   .rsp_occupancy (rsp_occupancy)
);
`default_nettype wire
